>>> hw/rtl/traffic_light_crossing_controller_unit_assert.svh
// Assertion macros used by the checker file of the crossing controller.
// Needs nothing else; include it by its bare file name.
`ifndef TRAFFIC_LIGHT_CROSSING_CONTROLLER_UNIT_ASSERT_SVH
`define TRAFFIC_LIGHT_CROSSING_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crossing controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crossing controller check failed");

`endif

>>> hw/rtl/tlcc_pkg.sv
// Shared types and constants of the traffic light crossing controller.
// No dependencies; the top level, tlcc_front, tlcc_ctrl and the testbench import it.
package tlcc_pkg;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_SWITCH = 2'd1;
    localparam logic [1:0] CMD_BUTTON = 2'd2;

    localparam logic [2:0] CFG_IDX_TPS        = 3'd0;
    localparam logic [2:0] CFG_IDX_RED_SEC    = 3'd1;
    localparam logic [2:0] CFG_IDX_GREEN_SEC  = 3'd2;
    localparam logic [2:0] CFG_IDX_CLEAR_SEC  = 3'd3;
    localparam logic [2:0] CFG_IDX_FLASH      = 3'd4;
    localparam logic [2:0] CFG_IDX_OPEN_DUTY  = 3'd5;
    localparam logic [2:0] CFG_IDX_CLOSE_DUTY = 3'd6;

    localparam logic [3:0] LAMP_RED    = 4'h1;
    localparam logic [3:0] LAMP_YELLOW = 4'h2;
    localparam logic [3:0] LAMP_GREEN  = 4'h4;
    localparam logic [3:0] LAMP_BLUE   = 4'h8;

    localparam logic [3:0] SW_MAINT = 4'h1;
    localparam logic [3:0] SW_TRAIN = 4'h2;

    localparam logic [3:0] PATTERN_YELLOW = 4'd15;
    localparam logic [3:0] PATTERN_RED    = 4'd0;

    localparam logic [13:0] SEC_MAX    = 14'd10000;
    localparam logic [13:0] DUTY_RESET = 14'd700;
    localparam logic [13:0] DUTY_BASE  = 14'd500;
    localparam logic [20:0] POT_GAIN   = 21'd500;
    localparam logic [20:0] POT_ROUND  = 21'd2047;
    localparam logic [12:0] POT_FULL   = 13'd4095;

    typedef enum logic [1:0] {
        PH_GREEN  = 2'd0,
        PH_YELLOW = 2'd1,
        PH_RED    = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]  ticks_per_second;
        logic [9:0]  red_seconds;
        logic [9:0]  green_min_seconds;
        logic [9:0]  clear_seconds;
        logic [9:0]  flash_ticks;
        logic [13:0] open_servo_duty;
        logic [13:0] closed_servo_duty;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ticks_per_second:  8'd10,
        red_seconds:       10'd10,
        green_min_seconds: 10'd10,
        clear_seconds:     10'd10,
        flash_ticks:       10'd100,
        open_servo_duty:   14'd500,
        closed_servo_duty: 14'd1000
    };

    // Registered input word plus the scaled pot product, pot * 500 + 2047.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  switches;
        logic [3:0]  buttons;
        logic [20:0] pot_prod;
    } t_stage;

    typedef struct packed {
        logic        red_lamp;
        logic        yellow_lamp;
        logic        green_lamp;
        logic        blue_lamp;
        logic [13:0] gate_duty;
        logic [3:0]  led_pattern;
        logic        in_maintenance;
        logic        train_present;
        logic        finished;
    } t_result;

endpackage

>>> hw/rtl/tlcc_ifs.sv
// Handshake channel interfaces of the crossing controller: input, result, config.
// Depends on nothing but the widths of the block's fields.
interface tlcc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  switches;
    logic [3:0]  buttons;
    logic [11:0] pot_sample;
    modport source (output valid, cmd, switches, buttons, pot_sample, input ready);
    modport sink   (input valid, cmd, switches, buttons, pot_sample, output ready);
endinterface

interface tlcc_out_if;
    logic        valid;
    logic        ready;
    logic        red_lamp;
    logic        yellow_lamp;
    logic        green_lamp;
    logic        blue_lamp;
    logic [13:0] gate_duty;
    logic [3:0]  led_pattern;
    logic        in_maintenance;
    logic        train_present;
    logic        finished;
    modport source (output valid, red_lamp, yellow_lamp, green_lamp, blue_lamp, gate_duty,
                    led_pattern, in_maintenance, train_present, finished, input ready);
    modport sink   (input valid, red_lamp, yellow_lamp, green_lamp, blue_lamp, gate_duty,
                    led_pattern, in_maintenance, train_present, finished, output ready);
endinterface

interface tlcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [13:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/traffic_light_crossing_controller_unit.sv
// An accepted word goes from the input register stage through the state update into
// the result register; both registers hold while the result channel stalls.
// Throughput: one word per cycle while the result channel does not stall; the state update loop sets the rate.
// Reset (synchronous, active low): green phase with green lamp on, gate duty 700,
// counters and mode flags cleared, and every timing register back to its default.
// Depends on tlcc_pkg, tlcc_ifs, tlcc_front and tlcc_ctrl.
module traffic_light_crossing_controller_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlcc_in_if.sink    i_in,
    tlcc_out_if.source o_out,
    tlcc_cfg_if.sink   i_cfg
);
    import tlcc_pkg::*;

    t_cfg    r_cfg;
    t_stage  w_stage;
    t_result w_result;
    logic    w_stage_valid;
    logic    w_advance;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_IDX_TPS:        r_cfg.ticks_per_second  <= i_cfg.data[7:0];
                CFG_IDX_RED_SEC:    r_cfg.red_seconds       <= i_cfg.data[9:0];
                CFG_IDX_GREEN_SEC:  r_cfg.green_min_seconds <= i_cfg.data[9:0];
                CFG_IDX_CLEAR_SEC:  r_cfg.clear_seconds     <= i_cfg.data[9:0];
                CFG_IDX_FLASH:      r_cfg.flash_ticks       <= i_cfg.data[9:0];
                CFG_IDX_OPEN_DUTY:  r_cfg.open_servo_duty   <= i_cfg.data;
                CFG_IDX_CLOSE_DUTY: r_cfg.closed_servo_duty <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    tlcc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_stage   (w_stage)
    );

    tlcc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_stage_valid),
        .i_stage   (w_stage),
        .i_cfg     (r_cfg),
        .i_ready   (o_out.ready),
        .o_advance (w_advance),
        .o_valid   (o_out.valid),
        .o_result  (w_result)
    );

    assign o_out.red_lamp       = w_result.red_lamp;
    assign o_out.yellow_lamp    = w_result.yellow_lamp;
    assign o_out.green_lamp     = w_result.green_lamp;
    assign o_out.blue_lamp      = w_result.blue_lamp;
    assign o_out.gate_duty      = w_result.gate_duty;
    assign o_out.led_pattern    = w_result.led_pattern;
    assign o_out.in_maintenance = w_result.in_maintenance;
    assign o_out.train_present  = w_result.train_present;
    assign o_out.finished       = w_result.finished;

endmodule

>>> hw/rtl/tlcc_front.sv
// Input register stage: captures an accepted word and the scaled pot product.
// Depends on tlcc_pkg and tlcc_in_if.
module tlcc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tlcc_in_if.sink         i_in,
    input  logic            i_advance,
    output logic            o_valid,
    output tlcc_pkg::t_stage o_stage
);
    import tlcc_pkg::*;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    assign i_in.ready = !r_valid || i_advance;

    always_comb begin
        n_stage.cmd      = i_in.cmd;
        n_stage.switches = i_in.switches;
        n_stage.buttons  = i_in.buttons;
        n_stage.pot_prod = {9'd0, i_in.pot_sample} * POT_GAIN + POT_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> hw/rtl/tlcc_ctrl.sv
// Controller state update and result register, one word per cycle while the result channel does not stall.
// Depends on tlcc_pkg.
module tlcc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tlcc_pkg::t_stage i_stage,
    input  tlcc_pkg::t_cfg   i_cfg,
    input  logic             i_ready,
    output logic             o_advance,
    output logic             o_valid,
    output tlcc_pkg::t_result o_result
);
    import tlcc_pkg::*;

    typedef struct packed {
        logic [7:0]  sub;
        logic [13:0] sec;
    } t_count;

    t_phase      r_phase, n_phase;
    logic        r_first, n_first;
    logic        r_maint, n_maint;
    logic        r_train, n_train;
    logic        r_clearing, n_clearing;
    logic        r_walk, n_walk;
    logic [7:0]  r_sub, n_sub;
    logic [13:0] r_sec, n_sec;
    logic [9:0]  r_flash, n_flash;
    logic        r_blue, n_blue;
    logic [3:0]  r_last_sw, n_last_sw;
    logic [3:0]  r_lamp, n_lamp;
    logic [13:0] r_duty, n_duty;
    logic [3:0]  r_pattern, n_pattern;
    logic        r_stopped, n_stopped;
    logic        r_out_valid;
    t_result     r_result, n_result;

    logic        w_advance;
    logic [8:0]  w_quot_lo;
    logic [12:0] w_rem;
    logic [9:0]  w_quot;
    logic [13:0] w_pot_duty;
    logic [3:0]  w_sw_diff;
    t_count      w_cnt;

    // One counted tick: sub-second count wraps at ticks_per_second, seconds saturate at 10000.
    function automatic t_count count_tick(input logic [7:0] sub, input logic [13:0] sec,
                                          input logic [7:0] tps);
        t_count c;
        c.sub = sub + 8'd1;
        c.sec = sec;
        if (c.sub >= tps) begin
            c.sub = 8'd0;
            c.sec = sec + 14'd1;
        end
        if (c.sec >= SEC_MAX) begin
            c.sec = SEC_MAX;
        end
        return c;
    endfunction

    // Divide by 4095 as x/4096 plus a correction: the remainder estimate stays
    // below twice the divisor since the quotient never exceeds 500.
    assign w_quot_lo  = i_stage.pot_prod[20:12];
    assign w_rem      = {1'b0, i_stage.pot_prod[11:0]} + {4'd0, w_quot_lo};
    assign w_quot     = {1'b0, w_quot_lo} + ((w_rem >= POT_FULL) ? 10'd1 : 10'd0);
    assign w_pot_duty = DUTY_BASE + {4'd0, w_quot};

    assign w_sw_diff = i_stage.switches ^ r_last_sw;
    assign w_cnt     = count_tick(r_sub, r_sec, i_cfg.ticks_per_second);

    assign w_advance = i_valid && (!r_out_valid || i_ready);

    // Next state.
    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first;
        n_maint    = r_maint;
        n_train    = r_train;
        n_clearing = r_clearing;
        n_walk     = r_walk;
        n_sub      = r_sub;
        n_sec      = r_sec;
        n_flash    = r_flash;
        n_blue     = r_blue;
        n_last_sw  = r_last_sw;
        n_lamp     = r_lamp;
        n_duty     = r_duty;
        n_pattern  = r_pattern;
        n_stopped  = r_stopped;
        if (!r_stopped) begin
            case (i_stage.cmd)
                CMD_TICK: begin
                    if (r_train) begin
                        n_lamp = LAMP_RED;
                        n_sub  = 8'd0;
                        n_sec  = 14'd0;
                    end else if (r_clearing && !r_maint) begin
                        n_sub = w_cnt.sub;
                        n_sec = w_cnt.sec;
                        if (w_cnt.sec >= {4'd0, i_cfg.clear_seconds}) begin
                            n_sub      = 8'd0;
                            n_sec      = 14'd0;
                            n_lamp     = 4'h0;
                            n_clearing = 1'b0;
                        end
                    end else if (r_maint) begin
                        n_clearing = 1'b0;
                        n_flash    = r_flash + 10'd1;
                        if (n_flash >= i_cfg.flash_ticks) begin
                            n_flash = 10'd0;
                            n_blue  = ~r_blue;
                        end
                        n_lamp = {n_blue, r_lamp[2:0]};
                        n_duty = w_pot_duty;
                    end else begin
                        case (r_phase)
                            PH_RED: begin
                                if (r_first) begin
                                    n_lamp  = r_lamp | LAMP_RED;
                                    n_first = 1'b0;
                                    n_duty  = i_cfg.open_servo_duty;
                                end
                                n_sub = w_cnt.sub;
                                n_sec = w_cnt.sec;
                                if (w_cnt.sec >= {4'd0, i_cfg.red_seconds}) begin
                                    n_sub   = 8'd0;
                                    n_sec   = 14'd0;
                                    n_phase = PH_GREEN;
                                    n_lamp  = LAMP_GREEN;
                                end
                            end
                            PH_YELLOW: begin
                                n_phase   = PH_RED;
                                n_lamp    = LAMP_RED;
                                n_pattern = PATTERN_RED;
                            end
                            default: begin
                                if (r_first) begin
                                    n_lamp  = r_lamp | LAMP_GREEN;
                                    n_first = 1'b0;
                                end
                                n_sub = w_cnt.sub;
                                n_sec = w_cnt.sec;
                                if (r_walk &&
                                    w_cnt.sec >= {4'd0, i_cfg.green_min_seconds}) begin
                                    n_sub     = 8'd0;
                                    n_sec     = 14'd0;
                                    n_phase   = PH_YELLOW;
                                    n_lamp    = LAMP_YELLOW;
                                    n_walk    = 1'b0;
                                    n_pattern = PATTERN_YELLOW;
                                end
                            end
                        endcase
                    end
                end
                CMD_SWITCH: begin
                    if (w_sw_diff == SW_MAINT) begin
                        n_lamp  = 4'h0;
                        n_maint = ~r_maint;
                        if (n_maint) begin
                            n_first = 1'b0;
                        end else begin
                            n_sub   = 8'd0;
                            n_sec   = 14'd0;
                            n_phase = PH_RED;
                            n_first = 1'b1;
                            n_lamp  = LAMP_RED;
                        end
                    end else if (w_sw_diff == SW_TRAIN) begin
                        n_train = ~r_train;
                        n_lamp  = 4'h0;
                        if (n_train) begin
                            n_first    = 1'b0;
                            n_clearing = 1'b1;
                            n_sub      = 8'd0;
                            n_sec      = 14'd0;
                            n_duty     = i_cfg.closed_servo_duty;
                        end else begin
                            n_first = 1'b1;
                        end
                    end
                    n_last_sw = i_stage.switches;
                end
                CMD_BUTTON: begin
                    // The lowest pressed button decides; the third one is a no-op.
                    if (i_stage.buttons[0] || i_stage.buttons[1]) begin
                        n_walk = 1'b1;
                    end else if (!i_stage.buttons[2] && i_stage.buttons[3]) begin
                        n_stopped = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result word from the updated state.
    always_comb begin
        n_result.red_lamp       = |(n_lamp & LAMP_RED);
        n_result.yellow_lamp    = |(n_lamp & LAMP_YELLOW);
        n_result.green_lamp     = |(n_lamp & LAMP_GREEN);
        n_result.blue_lamp      = |(n_lamp & LAMP_BLUE);
        n_result.gate_duty      = n_duty;
        n_result.led_pattern    = n_pattern;
        n_result.in_maintenance = n_maint;
        n_result.train_present  = n_train;
        n_result.finished       = n_stopped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_GREEN;
            r_first    <= 1'b1;
            r_maint    <= 1'b0;
            r_train    <= 1'b0;
            r_clearing <= 1'b0;
            r_walk     <= 1'b0;
            r_sub      <= 8'd0;
            r_sec      <= 14'd0;
            r_flash    <= 10'd0;
            r_blue     <= 1'b0;
            r_last_sw  <= 4'h0;
            r_lamp     <= LAMP_GREEN;
            r_duty     <= DUTY_RESET;
            r_pattern  <= 4'h0;
            r_stopped  <= 1'b0;
        end else if (w_advance) begin
            r_phase    <= n_phase;
            r_first    <= n_first;
            r_maint    <= n_maint;
            r_train    <= n_train;
            r_clearing <= n_clearing;
            r_walk     <= n_walk;
            r_sub      <= n_sub;
            r_sec      <= n_sec;
            r_flash    <= n_flash;
            r_blue     <= n_blue;
            r_last_sw  <= n_last_sw;
            r_lamp     <= n_lamp;
            r_duty     <= n_duty;
            r_pattern  <= n_pattern;
            r_stopped  <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_advance = w_advance;
    assign o_valid   = r_out_valid;
    assign o_result  = r_result;

endmodule

>>> hw/rtl/tlcc_checker.sv
// Port-level checks on the result channel of the crossing controller, with its bind.
// Depends on the assertion macro header and the top level's port names.
`include "traffic_light_crossing_controller_unit_assert.svh"

module tlcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_red_lamp,
    input logic        i_yellow_lamp,
    input logic        i_green_lamp,
    input logic        i_blue_lamp,
    input logic [13:0] i_gate_duty,
    input logic [3:0]  i_led_pattern,
    input logic        i_in_maintenance,
    input logic        i_train_present,
    input logic        i_finished
);
    logic        r_seen_finished;
    logic [25:0] w_word;

    assign w_word = {i_red_lamp, i_yellow_lamp, i_green_lamp, i_blue_lamp, i_gate_duty,
                     i_led_pattern, i_in_maintenance, i_train_present, i_finished};

    // Remembers that a delivered word already reported the stop button.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_finished <= 1'b0;
        end else if (i_valid && i_ready && i_finished) begin
            r_seen_finished <= 1'b1;
        end
    end

    `TLCC_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid)
    `TLCC_ASSERT_NEXT(a_word_hold, i_clk, i_rst_n, i_valid && !i_ready, $stable(w_word))
    `TLCC_ASSERT_NOW(a_train_red_only, i_clk, i_rst_n, i_valid && i_train_present, !i_green_lamp && !i_yellow_lamp && !i_blue_lamp)
    `TLCC_ASSERT_NOW(a_stop_sticky, i_clk, i_rst_n, i_valid && r_seen_finished, i_finished)

endmodule

bind traffic_light_crossing_controller_unit tlcc_checker u_tlcc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_red_lamp       (o_out.red_lamp),
    .i_yellow_lamp    (o_out.yellow_lamp),
    .i_green_lamp     (o_out.green_lamp),
    .i_blue_lamp      (o_out.blue_lamp),
    .i_gate_duty      (o_out.gate_duty),
    .i_led_pattern    (o_out.led_pattern),
    .i_in_maintenance (o_out.in_maintenance),
    .i_train_present  (o_out.train_present),
    .i_finished       (o_out.finished)
);

>>> tb/traffic_light_crossing_controller_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the traffic light crossing controller: a directed table, then
// random phases under several timing settings and idle patterns. Depends on tlcc_pkg,
// tlcc_ifs and the block's RTL.
module traffic_light_crossing_controller_unit_tb;
    import tlcc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned PHASES = 5;
    localparam int unsigned PHASE_WORDS [PHASES] = '{350, 350, 150, 350, 350};
    localparam int unsigned SEND_IDLE [PHASES]   = '{0, 49, 0, 35, 0};
    localparam int unsigned RECV_STALL [PHASES]  = '{0, 0, 49, 35, 0};

    localparam t_result NO_PIN = '0;
    localparam t_result RES_AT_RESET = '{1'b0, 1'b0, 1'b1, 1'b0, DUTY_RESET, PATTERN_RED,
                                        1'b0, 1'b0, 1'b0};
    localparam t_result RES_POT_LOW  = '{1'b0, 1'b0, 1'b0, 1'b0, 14'd500, PATTERN_RED,
                                        1'b1, 1'b0, 1'b0};
    localparam t_result RES_POT_HIGH = '{1'b0, 1'b0, 1'b0, 1'b0, 14'd1000, PATTERN_RED,
                                        1'b1, 1'b0, 1'b0};

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  switches;
        logic [3:0]  buttons;
        logic [11:0] pot;
        logic        pinned;
        t_result     want;
    } t_script_row;

    // Runs under the reset timing: walk buttons, maintenance with pot extremes,
    // a train passing, multi-bit switch changes and the unused command.
    localparam t_script_row DIRECTED [21] = '{
        '{CMD_UNUSED, 4'b0000, 4'b0000, 12'h000, 1'b1, RES_AT_RESET},
        '{CMD_TICK,   4'b0000, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_BUTTON, 4'b0000, 4'b0100, 12'h000, 1'b0, NO_PIN},
        '{CMD_BUTTON, 4'b0000, 4'b0001, 12'h000, 1'b0, NO_PIN},
        '{CMD_BUTTON, 4'b0000, 4'b0010, 12'h000, 1'b0, NO_PIN},
        '{CMD_SWITCH, 4'b1100, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_SWITCH, 4'b1101, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_TICK,   4'b0000, 4'b0000, 12'h000, 1'b1, RES_POT_LOW},
        '{CMD_TICK,   4'b0000, 4'b0000, 12'hFFF, 1'b1, RES_POT_HIGH},
        '{CMD_TICK,   4'b0000, 4'b0000, 12'h800, 1'b0, NO_PIN},
        '{CMD_SWITCH, 4'b1100, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_TICK,   4'b0000, 4'b0000, 12'h7FF, 1'b0, NO_PIN},
        '{CMD_SWITCH, 4'b1110, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_TICK,   4'b0000, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_SWITCH, 4'b1100, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_TICK,   4'b0000, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_SWITCH, 4'b1111, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_UNUSED, 4'b1111, 4'b1111, 12'hFFF, 1'b0, NO_PIN},
        '{CMD_SWITCH, 4'b0000, 4'b0000, 12'h000, 1'b0, NO_PIN},
        '{CMD_BUTTON, 4'b0000, 4'b1110, 12'h000, 1'b0, NO_PIN},
        '{CMD_TICK,   4'b0000, 4'b0000, 12'h555, 1'b0, NO_PIN}
    };

    logic i_clk;
    logic i_rst_n;

    tlcc_in_if  in_ch ();
    tlcc_out_if out_ch ();
    tlcc_cfg_if cfg_ch ();

    traffic_light_crossing_controller_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Controller state as the predictor tracks it.
    t_cfg        timing;
    t_phase      ctl_phase;
    logic        ctl_first_pass, ctl_maint, ctl_train, ctl_clearing, ctl_walk;
    logic        ctl_blue, ctl_stopped;
    logic [7:0]  ctl_sub;
    logic [13:0] ctl_sec;
    logic [9:0]  ctl_flash;
    logic [3:0]  ctl_last_sw, ctl_lamps, ctl_pattern;
    logic [13:0] ctl_duty;

    t_result     lamp_words_due [$];
    int unsigned mismatches;
    int unsigned send_idle_pct, recv_stall_pct;
    logic        pin_now;
    t_result     pin_want;
    logic [3:0]  sw_now;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic reset_crossing();
        timing         = CFG_RESET;
        ctl_phase      = PH_GREEN;
        ctl_first_pass = 1'b1;
        ctl_maint      = 1'b0;
        ctl_train      = 1'b0;
        ctl_clearing   = 1'b0;
        ctl_walk       = 1'b0;
        ctl_blue       = 1'b0;
        ctl_stopped    = 1'b0;
        ctl_sub        = '0;
        ctl_sec        = '0;
        ctl_flash      = '0;
        ctl_last_sw    = '0;
        ctl_lamps      = LAMP_GREEN;
        ctl_pattern    = '0;
        ctl_duty       = DUTY_RESET;
    endtask

    task automatic restart_seconds();
        ctl_sub = '0;
        ctl_sec = '0;
    endtask

    task automatic count_second();
        ctl_sub = ctl_sub + 8'd1;
        if (ctl_sub >= timing.ticks_per_second) begin
            ctl_sub = '0;
            ctl_sec = ctl_sec + 14'd1;
        end
        if (ctl_sec >= SEC_MAX) ctl_sec = SEC_MAX;
    endtask

    task automatic control_pass(input logic [11:0] pot);
        int unsigned scaled;
        if (ctl_train) begin
            ctl_lamps = LAMP_RED;
            restart_seconds();
        end else if (ctl_clearing && !ctl_maint) begin
            count_second();
            if (ctl_sec >= timing.clear_seconds) begin
                restart_seconds();
                ctl_lamps    = '0;
                ctl_clearing = 1'b0;
            end
        end else if (ctl_maint) begin
            ctl_clearing = 1'b0;
            ctl_flash    = ctl_flash + 10'd1;
            if (ctl_flash >= timing.flash_ticks) begin
                ctl_flash = '0;
                ctl_blue  = ~ctl_blue;
            end
            ctl_lamps = (ctl_lamps & ~LAMP_BLUE) | (ctl_blue ? LAMP_BLUE : 4'h0);
            // Five percent plus the pot share of another five, rounded half up.
            scaled   = (int'(pot) * 500 + 2047) / 4095;
            ctl_duty = DUTY_BASE + 14'(scaled);
        end else begin
            case (ctl_phase)
                PH_RED: begin
                    if (ctl_first_pass) begin
                        ctl_lamps      = ctl_lamps | LAMP_RED;
                        ctl_first_pass = 1'b0;
                        ctl_duty       = timing.open_servo_duty;
                    end
                    count_second();
                    if (ctl_sec >= timing.red_seconds) begin
                        restart_seconds();
                        ctl_phase = PH_GREEN;
                        ctl_lamps = LAMP_GREEN;
                    end
                end
                PH_YELLOW: begin
                    ctl_phase   = PH_RED;
                    ctl_lamps   = LAMP_RED;
                    ctl_pattern = PATTERN_RED;
                end
                default: begin
                    if (ctl_first_pass) begin
                        ctl_lamps      = ctl_lamps | LAMP_GREEN;
                        ctl_first_pass = 1'b0;
                    end
                    count_second();
                    if (ctl_walk && ctl_sec >= timing.green_min_seconds) begin
                        restart_seconds();
                        ctl_phase   = PH_YELLOW;
                        ctl_lamps   = LAMP_YELLOW;
                        ctl_walk    = 1'b0;
                        ctl_pattern = PATTERN_YELLOW;
                    end
                end
            endcase
        end
    endtask

    task automatic switch_update(input logic [3:0] sw);
        logic [3:0] changed;
        changed = sw ^ ctl_last_sw;
        if (changed == SW_MAINT) begin
            ctl_lamps = '0;
            ctl_maint = ~ctl_maint;
            if (ctl_maint) begin
                ctl_first_pass = 1'b0;
            end else begin
                restart_seconds();
                ctl_phase      = PH_RED;
                ctl_first_pass = 1'b1;
                ctl_lamps      = LAMP_RED;
            end
        end else if (changed == SW_TRAIN) begin
            ctl_train = ~ctl_train;
            ctl_lamps = '0;
            if (ctl_train) begin
                ctl_first_pass = 1'b0;
                ctl_clearing   = 1'b1;
                restart_seconds();
                ctl_duty = timing.closed_servo_duty;
            end else begin
                ctl_first_pass = 1'b1;
            end
        end
        ctl_last_sw = sw;
    endtask

    task automatic advance_crossing(input logic [1:0] cmd, input logic [3:0] sw,
                                    input logic [3:0] bt, input logic [11:0] pot,
                                    output t_result res);
        if (!ctl_stopped) begin
            case (cmd)
                CMD_TICK:   control_pass(pot);
                CMD_SWITCH: switch_update(sw);
                CMD_BUTTON: begin
                    // The lowest pressed button wins; the third one does nothing.
                    if (bt[0] || bt[1]) ctl_walk = 1'b1;
                    else if (!bt[2] && bt[3]) ctl_stopped = 1'b1;
                end
                default: ;
            endcase
        end
        res = '{ctl_lamps[0], ctl_lamps[1], ctl_lamps[2], ctl_lamps[3], ctl_duty,
                ctl_pattern, ctl_maint, ctl_train, ctl_stopped};
    endtask

    task automatic store_register(input logic [2:0] idx, input logic [13:0] value);
        case (idx)
            CFG_IDX_TPS:        timing.ticks_per_second  = value[7:0];
            CFG_IDX_RED_SEC:    timing.red_seconds       = value[9:0];
            CFG_IDX_GREEN_SEC:  timing.green_min_seconds = value[9:0];
            CFG_IDX_CLEAR_SEC:  timing.clear_seconds     = value[9:0];
            CFG_IDX_FLASH:      timing.flash_ticks       = value[9:0];
            CFG_IDX_OPEN_DUTY:  timing.open_servo_duty   = value;
            CFG_IDX_CLOSE_DUTY: timing.closed_servo_duty = value;
            default: ;
        endcase
    endtask

    task automatic compare_lamp_word(input t_result want, input t_result seen);
        if (seen.red_lamp !== want.red_lamp) begin
            $error("red_lamp: expected %0d, got %0d", want.red_lamp, seen.red_lamp);
            mismatches++;
        end
        if (seen.yellow_lamp !== want.yellow_lamp) begin
            $error("yellow_lamp: expected %0d, got %0d", want.yellow_lamp, seen.yellow_lamp);
            mismatches++;
        end
        if (seen.green_lamp !== want.green_lamp) begin
            $error("green_lamp: expected %0d, got %0d", want.green_lamp, seen.green_lamp);
            mismatches++;
        end
        if (seen.blue_lamp !== want.blue_lamp) begin
            $error("blue_lamp: expected %0d, got %0d", want.blue_lamp, seen.blue_lamp);
            mismatches++;
        end
        if (seen.gate_duty !== want.gate_duty) begin
            $error("gate_duty: expected %0d, got %0d", want.gate_duty, seen.gate_duty);
            mismatches++;
        end
        if (seen.led_pattern !== want.led_pattern) begin
            $error("led_pattern: expected %0d, got %0d", want.led_pattern, seen.led_pattern);
            mismatches++;
        end
        if (seen.in_maintenance !== want.in_maintenance) begin
            $error("in_maintenance: expected %0d, got %0d", want.in_maintenance,
                   seen.in_maintenance);
            mismatches++;
        end
        if (seen.train_present !== want.train_present) begin
            $error("train_present: expected %0d, got %0d", want.train_present,
                   seen.train_present);
            mismatches++;
        end
        if (seen.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, seen.finished);
            mismatches++;
        end
    endtask

    // Results are taken first, then the accepted input word is predicted.
    always @(posedge i_clk) begin : watch_channels
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                seen = '{out_ch.red_lamp, out_ch.yellow_lamp, out_ch.green_lamp,
                         out_ch.blue_lamp, out_ch.gate_duty, out_ch.led_pattern,
                         out_ch.in_maintenance, out_ch.train_present, out_ch.finished};
                if (lamp_words_due.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    mismatches++;
                end else begin
                    want = lamp_words_due.pop_front();
                    compare_lamp_word(want, seen);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                advance_crossing(in_ch.cmd, in_ch.switches, in_ch.buttons, in_ch.pot_sample,
                                 want);
                lamp_words_due.push_back(pin_now ? pin_want : want);
            end
            if (cfg_ch.valid && cfg_ch.ready) store_register(cfg_ch.index, cfg_ch.data);
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_word(input logic [1:0] cmd, input logic [3:0] sw,
                             input logic [3:0] bt, input logic [11:0] pot,
                             input logic pinned, input t_result want);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.cmd        = cmd;
        in_ch.switches   = sw;
        in_ch.buttons    = bt;
        in_ch.pot_sample = pot;
        pin_now          = pinned;
        pin_want         = want;
        in_ch.valid      = 1'b1;
        if (cmd == CMD_SWITCH) sw_now = sw;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (lamp_words_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [13:0] value);
        @(negedge i_clk);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic program_timing(input logic [7:0] tps, input logic [9:0] red_s,
                                  input logic [9:0] green_s, input logic [9:0] clear_s,
                                  input logic [9:0] flash, input logic [13:0] open_duty,
                                  input logic [13:0] closed_duty);
        write_register(CFG_IDX_TPS, 14'(tps));
        write_register(CFG_IDX_RED_SEC, 14'(red_s));
        write_register(CFG_IDX_GREEN_SEC, 14'(green_s));
        write_register(CFG_IDX_CLEAR_SEC, 14'(clear_s));
        write_register(CFG_IDX_FLASH, 14'(flash));
        write_register(CFG_IDX_OPEN_DUTY, open_duty);
        write_register(CFG_IDX_CLOSE_DUTY, closed_duty);
    endtask

    // Mostly ticks with a walk request now and then; switch words mostly flip the
    // maintenance or train bit so that every mode is entered and left again.
    task automatic random_word();
        int unsigned pick;
        int unsigned flavor;
        logic [3:0]  bt;
        logic [3:0]  sw;
        logic [11:0] pot;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            flavor = $urandom_range(0, 9);
            pot = (flavor == 0) ? 12'h000 : (flavor == 1) ? 12'hFFF : 12'($urandom);
            send_word(CMD_TICK, 4'($urandom), 4'($urandom), pot, 1'b0, NO_PIN);
        end else if (pick < 88) begin
            bt = 4'($urandom_range(0, 15));
            // A lone stop button would freeze the block for the rest of the run.
            if (bt == 4'b1000) bt = 4'b1001;
            send_word(CMD_BUTTON, 4'($urandom), bt, 12'($urandom), 1'b0, NO_PIN);
        end else if (pick < 97) begin
            flavor = $urandom_range(0, 9);
            if (flavor < 4)      sw = sw_now ^ SW_MAINT;
            else if (flavor < 7) sw = sw_now ^ SW_TRAIN;
            else if (flavor == 7) sw = sw_now ^ ($urandom_range(0, 1) ? 4'b0100 : 4'b1000);
            else if (flavor == 8) sw = 4'($urandom);
            else                  sw = sw_now;
            send_word(CMD_SWITCH, sw, 4'($urandom), 12'($urandom), 1'b0, NO_PIN);
        end else begin
            send_word(CMD_UNUSED, 4'($urandom), 4'($urandom), 12'($urandom), 1'b0, NO_PIN);
        end
    endtask

    initial begin
        int unsigned ph;
        int unsigned n;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_TICK;
        in_ch.switches   = '0;
        in_ch.buttons    = '0;
        in_ch.pot_sample = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_IDX_TPS;
        cfg_ch.data      = '0;
        pin_now          = 1'b0;
        pin_want         = NO_PIN;
        sw_now           = '0;
        mismatches       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        reset_crossing();

        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[k]) begin
            send_word(DIRECTED[k].cmd, DIRECTED[k].switches, DIRECTED[k].buttons,
                      DIRECTED[k].pot, DIRECTED[k].pinned, DIRECTED[k].want);
        end
        drain_results();

        for (ph = 0; ph < PHASES; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            case (ph)
                0: program_timing(8'd2, 10'd3, 10'd2, 10'd2, 10'd3, 14'd0, 14'd16383);
                1: program_timing(8'd0, 10'd0, 10'd0, 10'd0, 10'd0, 14'd10000, 14'd0);
                2: program_timing(8'd255, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                                  14'd16383, 14'd10000);
                3: program_timing(8'($urandom_range(1, 4)), 10'($urandom_range(1, 6)),
                                  10'($urandom_range(0, 5)), 10'($urandom_range(1, 6)),
                                  10'($urandom_range(1, 6)), 14'($urandom_range(0, 16383)),
                                  14'($urandom_range(0, 16383)));
                default: program_timing(8'd1, 10'd1, 10'd1, 10'd1, 10'd1,
                                        14'($urandom_range(0, 10000)),
                                        14'($urandom_range(0, 10000)));
            endcase
            for (n = 0; n < PHASE_WORDS[ph]; n++) begin
                random_word();
                // Now and then the sender holds off until the block has caught up.
                if (n == PHASE_WORDS[ph] / 2 || $urandom_range(0, 149) == 0) drain_results();
            end
            drain_results();
        end

        // Stop button last: nothing after it may change the reported state.
        send_word(CMD_BUTTON, sw_now, 4'b1000, 12'h000, 1'b0, NO_PIN);
        send_word(CMD_TICK, sw_now, 4'b0000, 12'hFFF, 1'b0, NO_PIN);
        send_word(CMD_SWITCH, sw_now ^ SW_MAINT, 4'b0000, 12'h000, 1'b0, NO_PIN);
        send_word(CMD_SWITCH, sw_now ^ SW_TRAIN, 4'b0000, 12'h000, 1'b0, NO_PIN);
        send_word(CMD_BUTTON, sw_now, 4'b0011, 12'h000, 1'b0, NO_PIN);
        send_word(CMD_UNUSED, sw_now, 4'b1111, 12'h123, 1'b0, NO_PIN);
        drain_results();
        repeat (4) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
